[sv/assert_macros.svh]
// Assertion helper macros for the shared segment table RTL.
// Included by modules that carry concurrent assertions; needs clk_i and rst_ni.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is asserted.
`define SST_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Implication checked at the same edge.
`define SST_IMPLY(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

[sv/sst_pkg.sv]
// Package for the shared segment table: sizes, codes, record type, states.
// No dependencies; imported by shared_segment_table.
`timescale 1ns / 1ps

package sst_pkg;

  localparam int SLOTS = 32;
  localparam int IDXW  = $clog2(SLOTS);
  localparam int CNTW  = 16;
  localparam int PAGEW = 21;

  localparam logic [31:0]     WIN_BASE = 32'h4000_0000;
  localparam logic [CNTW-1:0] CNT_MAX  = '1;
  localparam logic [31:0]     KEY_PRIV = 32'hFFFF_FFFF;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_NOTFOUND = 3'd1,
    ST_NOSLOT   = 3'd2,
    ST_NOMEM    = 3'd3,
    ST_INVALID  = 3'd4,
    ST_NOTASK   = 3'd5,
    ST_BUSY     = 3'd6
  } status_e;

  typedef enum logic [2:0] {
    ACT_GET    = 3'd0,
    ACT_ATTACH = 3'd1,
    ACT_DETACH = 3'd2,
    ACT_REMOVE = 3'd3,
    ACT_CTRL   = 3'd4
  } action_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_SCAN,
    S_EXEC
  } state_e;

  typedef struct packed {
    logic [31:0]      key;
    logic [PAGEW-1:0] pages;
    logic [31:0]      phys;
    logic [CNTW-1:0]  cnt;
  } entry_t;

endpackage

[sv/shared_segment_table.sv]
// Shared memory segment table: request sequencer, slot scanner and record memory.
// Depends on sst_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Channel   Direction  Handshake                         Payload
// request   in         start_i high while busy_o low     action_i .. dir_present_i
// result    out        done_o high for one cycle         status_o .. release_res_o
//
// Get and detach scan every slot through one compare unit, one slot per cycle
// from the record memory's single read port, and stop early on a hit. Attach,
// remove and control read one record. busy_o is high from acceptance until the
// result is registered, so one transaction is in flight at a time. Reset clears
// the slot valid bits at once, so no clearing pass is needed. The receiver cannot
// stall: done_o flags a result for exactly one cycle.

module shared_segment_table (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  output logic                 busy_o,
  output logic                 done_o,
  input  logic [2:0]           action_i,
  input  logic signed [31:0]   key_i,
  input  logic [31:0]          size_bytes_i,
  input  logic                 create_i,
  input  logic [5:0]           segment_i,
  input  logic [31:0]          address_i,
  input  logic                 round_down_i,
  input  logic                 read_only_i,
  input  logic [31:0]          granted_base_i,
  input  logic                 task_present_i,
  input  logic                 dir_present_i,
  output logic [2:0]           status_o,
  output logic [4:0]           slot_o,
  output logic [31:0]          virt_addr_o,
  output logic [31:0]          phys_base_o,
  output logic [sst_pkg::PAGEW-1:0] page_count_o,
  output logic                 writable_o,
  output logic                 release_res_o
);
  import sst_pkg::*;

  // Sequencer state and the latched request.
  state_e state_q, state_d;
  logic [2:0]  action_q;
  logic [31:0] key_q, size_q, addr_q, granted_q;
  logic [5:0]  seg_q;
  logic        create_q, round_q, ro_q, task_q, dir_q;

  // Record memory and per-slot valid bits.
  entry_t            mem_q [SLOTS];
  logic [SLOTS-1:0]  valid_q;
  logic [IDXW-1:0]   rd_addr;
  entry_t            rd_data_q;
  logic              rd_vld_q;
  logic              mem_we;
  logic [IDXW-1:0]   mem_waddr;
  entry_t            mem_wdata;
  logic              set_valid, clr_valid;

  // Scanner: issue index, the index whose data is now on the read port, and
  // what the scan has found so far.
  logic [IDXW:0]   idx_q;
  logic            pend_q;
  logic [IDXW-1:0] pidx_q;
  logic            hit_q, free_found_q;
  logic [IDXW-1:0] hit_idx_q, free_idx_q;
  entry_t          ent_q;
  logic            scan_hit, scan_end;

  // Result registers.
  logic [2:0]       status_q, status_d;
  logic [4:0]       slot_q, slot_d;
  logic [31:0]      virt_q, virt_d, phys_q, phys_d;
  logic [PAGEW-1:0] pages_q, pages_d;
  logic             wr_q, wr_d, rel_q, rel_d, done_q;

  logic             accept;
  logic [IDXW-1:0]  seg_idx;
  logic             seg_ok;
  logic [33:0]      win_lo, win_hi;
  logic             in_range;
  logic [PAGEW-1:0] new_pages;
  logic [31:0]      att_addr;
  entry_t           cur;

  assign accept  = start_i && (state_q == S_IDLE);
  assign seg_idx = seg_q[IDXW-1:0];
  assign rd_addr = (state_q == S_SCAN) ? idx_q[IDXW-1:0] : seg_idx;

  // Window of the slot under test; the end is kept in 34 bits so it never wraps.
  assign win_lo   = {2'b00, WIN_BASE} + ({{(34-IDXW){1'b0}}, pidx_q} << 20);
  assign win_hi   = win_lo + ({{(34-PAGEW){1'b0}}, rd_data_q.pages} << 12);
  assign in_range = ({2'b00, addr_q} >= win_lo) && ({2'b00, addr_q} < win_hi);

  always_comb begin
    scan_hit = 1'b0;
    if (pend_q) begin
      if (action_q == ACT_GET) begin
        scan_hit = rd_vld_q && (rd_data_q.key == key_q) && (key_q != KEY_PRIV);
      end else begin
        scan_hit = rd_vld_q && in_range;
      end
    end
  end
  assign scan_end = !pend_q && (idx_q == (IDXW+1)'(SLOTS));

  // Zero-size requests become one page; otherwise round up to whole pages.
  assign new_pages = (size_q == '0) ? PAGEW'(1)
                   : PAGEW'(size_q[31:12]) + PAGEW'(|size_q[11:0]);

  // A segment index is good when it names an existing, valid slot.
  assign seg_ok = ({26'd0, seg_q} < SLOTS) && rd_vld_q;

  // Default window first, then optional page rounding.
  always_comb begin
    att_addr = (addr_q == '0) ? WIN_BASE + ({26'd0, seg_q} << 20) : addr_q;
    if (round_q) begin
      att_addr[11:0] = '0;
    end
  end

  assign cur = ((action_q == ACT_GET) || (action_q == ACT_DETACH)) ? ent_q : rd_data_q;

  // Next state, result and table updates.
  always_comb begin
    state_d   = state_q;
    status_d  = ST_OK;
    slot_d    = '0;
    virt_d    = '0;
    phys_d    = '0;
    pages_d   = '0;
    wr_d      = 1'b0;
    rel_d     = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = seg_idx;
    mem_wdata = cur;
    set_valid = 1'b0;
    clr_valid = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          if ((action_i == ACT_GET) || (action_i == ACT_DETACH)) begin
            state_d = S_SCAN;
          end else begin
            state_d = S_READ;
          end
        end
      end
      S_READ: begin
        state_d = S_EXEC;
      end
      S_SCAN: begin
        if (scan_hit || scan_end) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d = S_IDLE;
        case (action_q)
          ACT_GET: begin
            if (hit_q) begin
              slot_d  = 5'(hit_idx_q);
              phys_d  = cur.phys;
              pages_d = cur.pages;
            end else if (!create_q) begin
              status_d = ST_NOTFOUND;
            end else if (!free_found_q) begin
              status_d = ST_NOSLOT;
            end else if (granted_q == '0) begin
              status_d = ST_NOMEM;
            end else begin
              slot_d          = 5'(free_idx_q);
              phys_d          = granted_q;
              pages_d         = new_pages;
              mem_we          = 1'b1;
              mem_waddr       = free_idx_q;
              mem_wdata.key   = key_q;
              mem_wdata.pages = new_pages;
              mem_wdata.phys  = granted_q;
              mem_wdata.cnt   = '0;
              set_valid       = 1'b1;
            end
          end
          ACT_ATTACH: begin
            slot_d = seg_q[4:0];
            if (!seg_ok) begin
              status_d = ST_INVALID;
            end else if (!task_q) begin
              status_d = ST_NOTASK;
            end else if (!dir_q) begin
              status_d = ST_INVALID;
            end else begin
              virt_d  = att_addr;
              phys_d  = cur.phys;
              pages_d = cur.pages;
              wr_d    = !ro_q;
              if (cur.cnt != CNT_MAX) begin
                mem_we        = 1'b1;
                mem_wdata.cnt = cur.cnt + CNTW'(1);
              end
            end
          end
          ACT_DETACH: begin
            if (hit_q) begin
              slot_d    = 5'(hit_idx_q);
              mem_waddr = hit_idx_q;
              if (cur.cnt != '0) begin
                mem_we        = 1'b1;
                mem_wdata.cnt = cur.cnt - CNTW'(1);
              end
            end else begin
              status_d = ST_INVALID;
            end
          end
          ACT_REMOVE: begin
            slot_d = seg_q[4:0];
            if (!seg_ok) begin
              status_d = ST_INVALID;
            end else if (cur.cnt != '0) begin
              status_d = ST_BUSY;
            end else begin
              phys_d    = cur.phys;
              pages_d   = cur.pages;
              rel_d     = 1'b1;
              clr_valid = 1'b1;
            end
          end
          default: begin
            // Control and the unused codes only check the slot.
            slot_d = seg_q[4:0];
            if (!seg_ok) begin
              status_d = ST_INVALID;
            end
          end
        endcase
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Control registers: valid bits, scanner flags, result strobe.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q      <= '0;
      pend_q       <= 1'b0;
      idx_q        <= '0;
      hit_q        <= 1'b0;
      free_found_q <= 1'b0;
      done_q       <= 1'b0;
    end else begin
      done_q <= (state_q == S_EXEC);
      if (set_valid) begin
        valid_q[mem_waddr] <= 1'b1;
      end
      if (clr_valid) begin
        valid_q[seg_idx] <= 1'b0;
      end
      if (accept) begin
        idx_q        <= '0;
        pend_q       <= 1'b0;
        hit_q        <= 1'b0;
        free_found_q <= 1'b0;
      end else if (state_q == S_SCAN) begin
        pend_q <= (idx_q < (IDXW+1)'(SLOTS)) && !scan_hit;
        if (idx_q < (IDXW+1)'(SLOTS)) begin
          idx_q <= idx_q + (IDXW+1)'(1);
        end
        if (scan_hit) begin
          hit_q <= 1'b1;
        end
        if (pend_q && !rd_vld_q && !free_found_q) begin
          free_found_q <= 1'b1;
        end
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      action_q  <= action_i;
      key_q     <= key_i;
      size_q    <= size_bytes_i;
      create_q  <= create_i;
      seg_q     <= segment_i;
      addr_q    <= address_i;
      round_q   <= round_down_i;
      ro_q      <= read_only_i;
      granted_q <= granted_base_i;
      task_q    <= task_present_i;
      dir_q     <= dir_present_i;
    end
    if (state_q == S_SCAN) begin
      pidx_q <= idx_q[IDXW-1:0];
      if (scan_hit) begin
        hit_idx_q <= pidx_q;
        ent_q     <= rd_data_q;
      end
      if (pend_q && !rd_vld_q && !free_found_q) begin
        free_idx_q <= pidx_q;
      end
    end
    if (state_q == S_EXEC) begin
      status_q <= status_d;
      slot_q   <= slot_d;
      virt_q   <= virt_d;
      phys_q   <= phys_d;
      pages_q  <= pages_d;
      wr_q     <= wr_d;
      rel_q    <= rel_d;
    end
  end

  // Record memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    rd_data_q <= mem_q[rd_addr];
    rd_vld_q  <= valid_q[rd_addr];
  end

  assign busy_o        = (state_q != S_IDLE);
  assign done_o        = done_q;
  assign status_o      = status_q;
  assign slot_o        = slot_q;
  assign virt_addr_o   = virt_q;
  assign phys_base_o   = phys_q;
  assign page_count_o  = pages_q;
  assign writable_o    = wr_q;
  assign release_res_o = rel_q;

  `SST_IMPLY(a_done_idle, done_o, !busy_o, "result strobe while busy")
  `SST_ASSERT(a_exec_done, (state_q == S_EXEC) |=> done_o, "execute step gave no result")
  `SST_IMPLY(a_rel_ok, done_o && release_res_o, status_o == ST_OK, "release without ok")
  `SST_ASSERT(a_accept_busy, (start_i && !busy_o) |=> busy_o, "accepted request not busy")

endmodule
